>>> hdl/clfs_pkg.sv
// Package for the lenient CSV field splitter.
// Holds the result kinds, register indexes, character constants and shared structs.
// Depends on nothing.
package clfs_pkg;

    typedef enum logic [1:0] {
        KIND_CONTENT    = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    localparam logic [1:0] REG_FIELD_DELIMITER = 2'd0;
    localparam logic [1:0] REG_QUOTE_CHARACTER = 2'd1;
    localparam logic [1:0] REG_CRLF_MODE       = 2'd2;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [7:0] RESET_DELIMITER = 8'd44;
    localparam logic [7:0] RESET_QUOTE     = 8'd34;

    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = 2;

    typedef struct packed {
        logic [7:0] field_delimiter;
        logic [7:0] quote_character;
        logic       crlf_mode;
    } cfg_t;

    typedef struct packed {
        logic inside_quotes;
        logic at_field_start;
        logic quote_pending;
        logic cr_pending;
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]   count;
        result_t      res0;
        result_t      res1;
        parse_state_t next_state;
    } step_t;

endpackage

>>> hdl/clfs_step.sv
// Combinational parse step of the lenient CSV field splitter.
// Maps one byte and the current parser flags to up to two results and the next flags.
// Depends on clfs_pkg.
module clfs_step (
    input  clfs_pkg::cfg_t         cfg,
    input  clfs_pkg::parse_state_t state,
    input  logic [7:0]             in_byte,
    output clfs_pkg::step_t        step
);
    import clfs_pkg::*;

    parse_state_t n;
    result_t      res [2];
    logic [1:0]   cnt;
    logic         done;

    always_comb begin
        n      = state;
        cnt    = 2'd0;
        done   = 1'b0;
        res[0] = '{kind: KIND_CONTENT, data: 8'd0, last: 1'b0};
        res[1] = '{kind: KIND_CONTENT, data: 8'd0, last: 1'b0};

        if (state.cr_pending) begin
            n.cr_pending = 1'b0;
            if (cfg.crlf_mode && in_byte == CHAR_LF) begin
                res[cnt[0]] = '{kind: KIND_RECORD_END, data: 8'd0, last: 1'b0};
                cnt = cnt + 2'd1;
                n.at_field_start = 1'b1;
                done = 1'b1;
            end else begin
                res[cnt[0]] = '{kind: KIND_CONTENT, data: CHAR_CR, last: 1'b0};
                cnt = cnt + 2'd1;
            end
        end

        if (!done && state.quote_pending) begin
            n.quote_pending = 1'b0;
            if (in_byte == cfg.quote_character) begin
                res[cnt[0]] = '{kind: KIND_CONTENT, data: in_byte, last: 1'b0};
                cnt = cnt + 2'd1;
                done = 1'b1;
            end else begin
                n.inside_quotes  = 1'b0;
                n.at_field_start = 1'b0;
            end
        end

        if (!done) begin
            if (n.inside_quotes) begin
                if (in_byte == cfg.quote_character) begin
                    n.quote_pending = 1'b1;
                end else begin
                    res[cnt[0]] = '{kind: KIND_CONTENT, data: in_byte, last: 1'b0};
                    cnt = cnt + 2'd1;
                end
            end else if (in_byte == CHAR_LF) begin
                res[cnt[0]] = '{kind: KIND_RECORD_END, data: 8'd0, last: 1'b0};
                cnt = cnt + 2'd1;
                n.at_field_start = 1'b1;
            end else if (in_byte == cfg.field_delimiter) begin
                res[cnt[0]] = '{kind: KIND_FIELD_END, data: 8'd0, last: 1'b0};
                cnt = cnt + 2'd1;
                n.at_field_start = 1'b1;
            end else if (in_byte == cfg.quote_character && n.at_field_start) begin
                n.inside_quotes  = 1'b1;
                n.at_field_start = 1'b0;
            end else if (in_byte == CHAR_CR && cfg.crlf_mode) begin
                n.cr_pending     = 1'b1;
                n.at_field_start = 1'b0;
            end else begin
                res[cnt[0]] = '{kind: KIND_CONTENT, data: in_byte, last: 1'b0};
                cnt = cnt + 2'd1;
                n.at_field_start = 1'b0;
            end
        end

        res[0].last = (cnt == 2'd1);
        res[1].last = 1'b1;

        step.count      = cnt;
        step.res0       = res[0];
        step.res1       = res[1];
        step.next_state = n;
    end

endmodule

>>> hdl/csv_lenient_field_splitter_unit.sv
// Top level of the lenient CSV field splitter: handshakes, configuration registers,
// parser flags and a four-entry result queue.
// Depends on clfs_pkg and clfs_step.
//
// The unit takes one CSV byte per transfer and returns content bytes, end-of-field and
// end-of-record markers; m_last marks the final result caused by each input byte. A byte
// is taken in every cycle while the result queue has room for two results, so the
// sustained rate is one byte per clock; a byte that yields two results (a held carriage
// return released as content) is absorbed by the queue. The first result of a byte can be
// taken in the cycle after its transfer. Configuration writes are always accepted and should
// be made only while the unit is idle.
module csv_lenient_field_splitter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import clfs_pkg::*;

    cfg_t                    cfg_reg;
    parse_state_t            state_reg;
    step_t                   step;
    result_t                 queue_reg [RESULT_DEPTH];
    logic [RESULT_PTR_W-1:0] wr_ptr_reg;
    logic [RESULT_PTR_W-1:0] rd_ptr_reg;
    logic [RESULT_PTR_W:0]   count_reg;
    logic [RESULT_PTR_W:0]   count_next;
    logic                    in_xfer;
    logic                    out_xfer;
    logic [1:0]              push_cnt;

    clfs_step u_step (
        .cfg     (cfg_reg),
        .state   (state_reg),
        .in_byte (s_in_byte),
        .step    (step)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= (RESULT_PTR_W + 1)'(RESULT_DEPTH - 2));
    assign m_valid   = (count_reg != '0);
    assign in_xfer   = s_valid && s_ready;
    assign out_xfer  = m_valid && m_ready;
    assign push_cnt  = in_xfer ? step.count : 2'd0;

    assign m_kind     = queue_reg[rd_ptr_reg].kind;
    assign m_out_byte = queue_reg[rd_ptr_reg].data;
    assign m_last     = queue_reg[rd_ptr_reg].last;

    always_comb begin
        count_next = count_reg + {{(RESULT_PTR_W - 1){1'b0}}, push_cnt}
                   - {{RESULT_PTR_W{1'b0}}, out_xfer};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_delimiter <= RESET_DELIMITER;
            cfg_reg.quote_character <= RESET_QUOTE;
            cfg_reg.crlf_mode       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FIELD_DELIMITER: cfg_reg.field_delimiter <= cfg_data;
                REG_QUOTE_CHARACTER: cfg_reg.quote_character <= cfg_data;
                REG_CRLF_MODE:       cfg_reg.crlf_mode       <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{inside_quotes: 1'b0, at_field_start: 1'b1,
                           quote_pending: 1'b0, cr_pending: 1'b0};
        end else if (in_xfer) begin
            state_reg <= step.next_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RESULT_PTR_W'(push_cnt);
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= step.res0;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= step.res1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (RESULT_PTR_W + 1)'(RESULT_DEPTH))
        else $error("result queue overflow");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && step.count != 2'd0) |=> m_valid)
        else $error("accepted byte produced no visible result");

    a_quote_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.quote_pending |-> state_reg.inside_quotes)
        else $error("pending quote outside quoted mode");

    a_single_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.quote_pending && state_reg.cr_pending))
        else $error("quote and carriage return pending together");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

>>> tb/sv/clfs_token_checker.sv
`timescale 1ns / 1ps
// Result checker for the lenient CSV field splitter: it watches the byte, result and register
// channels, runs its own parser model on every accepted byte and compares each result transfer.
// Depends on clfs_pkg.
module clfs_token_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_kind,
    input  logic [7:0] m_out_byte,
    input  logic       m_last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatch_count,
    output int         pending_count,
    output int         checked_count
);
    import clfs_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } token_t;

    token_t     expected_tokens[$];
    token_t     step_tokens[$];

    logic [7:0] delimiter  = RESET_DELIMITER;
    logic [7:0] quote_byte = RESET_QUOTE;
    logic       crlf_on    = 1'b0;

    logic       in_quotes  = 1'b0;
    logic       at_start   = 1'b1;
    logic       quote_held = 1'b0;
    logic       cr_held    = 1'b0;

    int         errors  = 0;
    int         checked = 0;

    function automatic void stage(kind_t k, logic [7:0] d);
        token_t t;
        t.kind = k;
        t.data = d;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void split_byte(logic [7:0] b);
        logic done;
        done = 1'b0;
        step_tokens.delete();
        if (cr_held) begin
            cr_held = 1'b0;
            if (crlf_on && b == CHAR_LF) begin
                stage(KIND_RECORD_END, 8'd0);
                at_start = 1'b1;
                done = 1'b1;
            end else begin
                stage(KIND_CONTENT, CHAR_CR);
            end
        end
        if (!done && quote_held) begin
            quote_held = 1'b0;
            if (b == quote_byte) begin
                stage(KIND_CONTENT, b);
                done = 1'b1;
            end else begin
                in_quotes = 1'b0;
                at_start = 1'b0;
            end
        end
        if (!done) begin
            if (in_quotes) begin
                if (b == quote_byte) begin
                    quote_held = 1'b1;
                end else begin
                    stage(KIND_CONTENT, b);
                end
            end else if (b == CHAR_LF) begin
                stage(KIND_RECORD_END, 8'd0);
                at_start = 1'b1;
            end else if (b == delimiter) begin
                stage(KIND_FIELD_END, 8'd0);
                at_start = 1'b1;
            end else if (b == quote_byte && at_start) begin
                in_quotes = 1'b1;
                at_start = 1'b0;
            end else if (b == CHAR_CR && crlf_on) begin
                cr_held = 1'b1;
                at_start = 1'b0;
            end else begin
                stage(KIND_CONTENT, b);
                at_start = 1'b0;
            end
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            expected_tokens.push_back(step_tokens[i]);
        end
    endfunction

    always @(posedge aclk) begin
        token_t want;
        logic   bad;
        if (!aresetn) begin
            expected_tokens.delete();
            delimiter = RESET_DELIMITER;
            quote_byte = RESET_QUOTE;
            crlf_on = 1'b0;
            in_quotes = 1'b0;
            at_start = 1'b1;
            quote_held = 1'b0;
            cr_held = 1'b0;
            errors = 0;
            checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIELD_DELIMITER: delimiter = cfg_data;
                    REG_QUOTE_CHARACTER: quote_byte = cfg_data;
                    REG_CRLF_MODE:       crlf_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                split_byte(s_in_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with none expected: %s %0d, %0h, %0b",
                             $time, "kind, byte, last", m_kind, m_out_byte, m_last);
                end else begin
                    want = expected_tokens.pop_front();
                    bad = 1'b0;
                    if (m_kind !== want.kind) begin
                        bad = 1'b1;
                        $display("%0t: kind expected %0d, got %0d", $time, want.kind, m_kind);
                    end
                    if (m_out_byte !== want.data) begin
                        bad = 1'b1;
                        $display("%0t: out_byte expected 0x%02h, got 0x%02h",
                                 $time, want.data, m_out_byte);
                    end
                    if (m_last !== want.last) begin
                        bad = 1'b1;
                        $display("%0t: last expected %0b, got %0b", $time, want.last, m_last);
                    end
                    if (bad) begin
                        errors++;
                    end
                    checked++;
                end
            end
        end
        mismatch_count <= errors;
        pending_count  <= expected_tokens.size();
        checked_count  <= checked;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the CSV splitter testbench: clock, reset, byte and register stimulus, result-side
// back-pressure, an inactivity watchdog and the verdict.
// Depends on clfs_pkg, clfs_token_checker and csv_lenient_field_splitter_unit.
module tb_top;
    import clfs_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 128;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 2000;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_FIELD_DELIMITER;
    logic [7:0] cfg_data  = 8'd0;

    int         mismatches;
    int         pending;
    int         checked;
    int         bytes_sent    = 0;
    int         settings_used = 0;
    int         idle_cycles   = 0;
    logic       quiet_mode    = 1'b0;
    logic       hold_request  = 1'b0;
    logic [7:0] cur_delim     = RESET_DELIMITER;
    logic [7:0] cur_quote     = RESET_QUOTE;
    logic       cur_crlf      = 1'b0;

    csv_lenient_field_splitter_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    clfs_token_checker token_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .checked_count  (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: a random stall before each transfer outside quiet mode, plus one long hold-off on request.
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_splitter(input logic [7:0] delim, input logic [7:0] quote,
                                input logic crlf);
        write_reg(REG_FIELD_DELIMITER, delim);
        write_reg(REG_QUOTE_CHARACTER, quote);
        write_reg(REG_CRLF_MODE, {7'd0, crlf});
        cfg_valid <= 1'b0;
        cur_delim = delim;
        cur_quote = quote;
        cur_crlf  = crlf;
        settings_used++;
    endtask

    // Waits until every expected result has been taken, then lets the unit settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0:       send_byte(cur_delim);
            1:       send_byte(cur_quote);
            2:       send_byte(CHAR_CR);
            3:       send_byte(CHAR_LF);
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_record();
        int n_fields;
        int len;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) begin
                send_byte(cur_delim);
            end
            if ($urandom_range(0, 2) == 0) begin
                send_byte(cur_quote);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(cur_quote);
                        send_byte(cur_quote);
                    end else begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
                send_byte(cur_quote);
                if ($urandom_range(0, 4) == 0) begin
                    send_byte($urandom_range(0, 1) == 1 ? cur_quote : 8'($urandom_range(0, 255)));
                end
            end else begin
                len = $urandom_range(0, 5);
                repeat (len) send_byte(8'($urandom_range(0, 255)));
            end
        end
        if (cur_crlf && $urandom_range(0, 1) == 1) begin
            send_byte(CHAR_CR);
        end
        send_byte(CHAR_LF);
    endtask

    initial begin
        logic [7:0] seq[$];
        int         phase_start;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        seq = '{8'h2c, 8'h62, CHAR_LF,
                8'h22, 8'h22, 8'h22, 8'h79, 8'h22, 8'h7a, 8'h22, 8'h2c,
                8'h00, 8'hff, CHAR_CR, CHAR_LF};
        foreach (seq[i]) send_byte(seq[i]);
        drain();

        set_splitter(RESET_DELIMITER, RESET_QUOTE, 1'b1);
        seq = '{8'h71, CHAR_CR, CHAR_LF, CHAR_CR, 8'h6b, 8'h2c,
                8'h22, CHAR_CR, 8'h22, CHAR_CR, CHAR_LF, CHAR_CR};
        foreach (seq[i]) send_byte(seq[i]);
        drain();

        // A carriage return is still held here; clearing CRLF mode must release it as content.
        set_splitter(RESET_DELIMITER, RESET_QUOTE, 1'b0);
        send_byte(CHAR_LF);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       set_splitter(RESET_DELIMITER, RESET_QUOTE, 1'b0);
                1:       set_splitter(8'h00, 8'hff, 1'b1);
                2:       set_splitter(8'hff, 8'h00, 1'b0);
                3:       set_splitter(8'h09, 8'h27, 1'b1);
                4:       set_splitter(8'h3b, 8'h3b, 1'b1);
                5:       set_splitter(CHAR_CR, CHAR_LF, 1'b1);
                default: set_splitter(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
            endcase
            quiet_mode = (p % 3 == 1) || (p == 3);
            if (p == 3) begin
                hold_request = 1'b1;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_record();
                end
            end
        end
        drain();

        $display("Sent %0d CSV bytes under %0d delimiter, quote and CRLF settings.",
                 bytes_sent, settings_used);
        $display("Checked %0d result transfers; %0d were wrong or unexpected.", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/clfs_pkg.sv
hdl/clfs_step.sv
hdl/csv_lenient_field_splitter_unit.sv
tb/sv/clfs_token_checker.sv
tb/sv/tb_top.sv
